FILE: rtl/core/arrive_steering_step_top_defines.svh
// Assertion macros shared by the arrive steering step RTL.
// Define NO_ASSERTIONS to compile every check out of the design.
`ifndef ARRIVE_STEERING_STEP_TOP_DEFINES_SVH
`define ARRIVE_STEERING_STEP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that is held off while reset is high.
`define ASTR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that holds at every edge, reset included.
`define ASTR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASTR_ASSERT(label, clk, rst, prop, msg)
`define ASTR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/astr_pkg.sv
// Shared types and constants for the arrive steering step block.
// No dependencies; every other file but the macros header imports it.
package astr_pkg;

  // Field and register widths.
  localparam int POS_W   = 24;
  localparam int VEL_W   = 20;
  localparam int DT_W    = 16;
  localparam int SPEED_W = 19;
  localparam int ACCEL_W = 24;
  localparam int RAD_W   = 23;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_STOP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SLOW = 2'd3;

  // Register reset values.
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = 19'd25600;
  localparam logic [ACCEL_W-1:0] MAX_ACCEL_RST   = 24'd51200;
  localparam logic [RAD_W-1:0]   RADIUS_STOP_RST = 23'd2048;
  localparam logic [RAD_W-1:0]   RADIUS_SLOW_RST = 23'd16384;

  // Iteration counts of the shared square root and divide units.
  localparam int SQRT_STEPS = 26;
  localparam int DIV_STEPS  = 25;
  localparam int CNT_W      = $clog2(SQRT_STEPS);

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_SQ_D,
    OP_SQ_A,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIST,
    OP_AMAG,
    OP_MUL_SPD,
    OP_MUL_DX,
    OP_MUL_DY,
    OP_MUL_AX,
    OP_MUL_AY,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SPEED,
    OP_DESX,
    OP_DESY,
    OP_ACCEL,
    OP_LIMX,
    OP_LIMY,
    OP_DV,
    OP_VEL,
    OP_DP,
    OP_POS,
    OP_OUT
  } op_t;

  // Divisor choice for the divide unit.
  typedef enum logic [1:0] {
    DSEL_SLOW,
    DSEL_DIST,
    DSEL_AMAG
  } dsel_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_t   op;
    dsel_t dsel;
  } cmd_t;

endpackage

FILE: rtl/core/astr_in_if.sv
// Input channel of the arrive steering step block: target point and time step.
// Depends on astr_pkg for the field widths.
interface astr_in_if;
  import astr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic [DT_W-1:0]         time_step;

  modport source (output valid, output target_x, output target_y, output time_step,
                  input ready);
  modport sink (input valid, input target_x, input target_y, input time_step,
                output ready);
endinterface

FILE: rtl/core/astr_out_if.sv
// Output channel of the arrive steering step block: new position and velocity.
// Depends on astr_pkg for the field widths.
interface astr_out_if;
  import astr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;

  modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                output ready);
endinterface

FILE: rtl/core/astr_datapath.sv
// Datapath of the arrive steering step: state, configuration registers,
// shared multiplier, square root and divide units. Depends on astr_pkg.
module astr_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  astr_pkg::cmd_t                   cmd,
  input  logic                             cfg_write,
  input  logic [astr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [astr_pkg::CFG_W-1:0]       cfg_data,
  input  logic signed [astr_pkg::POS_W-1:0] target_x,
  input  logic signed [astr_pkg::POS_W-1:0] target_y,
  input  logic [astr_pkg::DT_W-1:0]        time_step,
  output logic signed [astr_pkg::POS_W-1:0] pos_x,
  output logic signed [astr_pkg::POS_W-1:0] pos_y,
  output logic signed [astr_pkg::VEL_W-1:0] vel_x,
  output logic signed [astr_pkg::VEL_W-1:0] vel_y
);
  import astr_pkg::*;

  // Configuration registers.
  logic [SPEED_W-1:0] max_speed;
  logic [ACCEL_W-1:0] max_accel;
  logic [RAD_W-1:0]   radius_stop;
  logic [RAD_W-1:0]   radius_slow;

  // Block state.
  logic signed [POS_W-1:0] posx, posy;
  logic signed [VEL_W-1:0] velx, vely;

  // Working registers of one item.
  logic signed [POS_W-1:0] tx, ty;
  logic [DT_W-1:0]         dt;
  logic signed [24:0]      dx, dy;
  logic [49:0]             sq_a, sq_b;
  logic [51:0]             rad;
  logic [27:0]             srem;
  logic [25:0]             root;
  logic [24:0]             dlen;
  logic [SPEED_W-1:0]      speed;
  logic [49:0]             prod;
  logic [24:0]             dlow;
  logic [25:0]             drem, dvs;
  logic signed [VEL_W-1:0] desx, desy;
  logic signed [25:0]      ax, ay;
  logic [25:0]             amag;
  logic signed [25:0]      dvx, dvy;
  logic signed [VEL_W-1:0] dpx, dpy;

  // Combinational helpers.
  logic [24:0] dxm, dym, axm, aym;
  logic [19:0] vxm, vym;
  logic [29:0] s_t, s_trial;
  logic [26:0] d_t, d_diff;
  logic        d_ge;
  logic [40:0] pax, pay;
  logic [35:0] pvx, pvy;
  logic signed [20:0] ex, ey;
  logic signed [25:0] ex26, ey26;
  logic [25:0] q26;
  logic [19:0] q20;
  logic signed [26:0] vsx, vsy;
  logic signed [24:0] psx, psy;

  // Clamp a velocity sum to plus or minus the speed limit.
  function automatic logic signed [VEL_W-1:0] clamp_vel(input logic signed [26:0] v,
                                                        input logic [SPEED_W-1:0] lim);
    logic signed [26:0] l;
    l = $signed({8'b0, lim});
    if (v > l) return VEL_W'(l);
    if (v < -l) return VEL_W'(-l);
    return VEL_W'(v);
  endfunction

  // Saturate a position sum to the signed 24-bit range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [24:0] v);
    if (v > 25'sd8388607) return 24'sh7FFFFF;
    if (v < -25'sd8388608) return 24'sh800000;
    return POS_W'(v);
  endfunction

  always_comb begin
    dxm = dx[24] ? 25'(-dx) : 25'(dx);
    dym = dy[24] ? 25'(-dy) : 25'(dy);
    axm = ax[25] ? 25'(-ax) : 25'(ax);
    aym = ay[25] ? 25'(-ay) : 25'(ay);
    vxm = velx[19] ? 20'(-velx) : 20'(velx);
    vym = vely[19] ? 20'(-vely) : 20'(vely);
    // One square root iteration: bring down two radicand bits.
    s_t = {srem, rad[51:50]};
    s_trial = {2'b00, root, 2'b01};
    // One restoring division iteration.
    d_t = {drem, dlow[24]};
    d_diff = d_t - {1'b0, dvs};
    d_ge = d_t >= {1'b0, dvs};
    // Time step products, truncated toward zero on the magnitude.
    pax = axm * dt;
    pay = aym * dt;
    pvx = vxm * dt;
    pvy = vym * dt;
    // Velocity error, sign extended.
    ex = {desx[19], desx} - {velx[19], velx};
    ey = {desy[19], desy} - {vely[19], vely};
    ex26 = 26'(ex);
    ey26 = 26'(ey);
    q26 = {1'b0, dlow};
    q20 = {1'b0, dlow[18:0]};
    vsx = 27'(velx) + 27'(dvx);
    vsy = 27'(vely) + 27'(dvy);
    psx = 25'(posx) + 25'(dpx);
    psy = 25'(posy) + 25'(dpy);
  end

  // Configuration writes and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= MAX_SPEED_RST;
      max_accel <= MAX_ACCEL_RST;
      radius_stop <= RADIUS_STOP_RST;
      radius_slow <= RADIUS_SLOW_RST;
      posx <= '0;
      posy <= '0;
      velx <= '0;
      vely <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAX_SPEED:   max_speed <= cfg_data[SPEED_W-1:0];
          CFG_MAX_ACCEL:   max_accel <= cfg_data[ACCEL_W-1:0];
          CFG_RADIUS_STOP: radius_stop <= cfg_data[RAD_W-1:0];
          CFG_RADIUS_SLOW: radius_slow <= cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_VEL) begin
        velx <= clamp_vel(vsx, max_speed);
        vely <= clamp_vel(vsy, max_speed);
      end
      if (cmd.op == OP_POS) begin
        posx <= sat_pos(psx);
        posy <= sat_pos(psy);
      end
    end
  end

  // Working registers, one operation per cycle.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        tx <= target_x;
        ty <= target_y;
        dt <= time_step;
      end
      OP_DIFF: begin
        dx <= 25'(tx) - 25'(posx);
        dy <= 25'(ty) - 25'(posy);
      end
      OP_SQ_D: begin
        sq_a <= dxm * dxm;
        sq_b <= dym * dym;
      end
      OP_SQ_A: begin
        sq_a <= axm * axm;
        sq_b <= aym * aym;
      end
      OP_SQRT_INIT: begin
        rad <= {1'b0, {1'b0, sq_a} + {1'b0, sq_b}};
        srem <= '0;
        root <= '0;
      end
      OP_SQRT_STEP: begin
        rad <= {rad[49:0], 2'b00};
        if (s_t >= s_trial) begin
          srem <= 28'(s_t - s_trial);
          root <= {root[24:0], 1'b1};
        end else begin
          srem <= s_t[27:0];
          root <= {root[24:0], 1'b0};
        end
      end
      OP_DIST: dlen <= root[24:0];
      OP_AMAG: amag <= root;
      OP_MUL_SPD: prod <= 50'(max_speed) * 50'(dlen);
      OP_MUL_DX:  prod <= 50'(dxm) * 50'(speed);
      OP_MUL_DY:  prod <= 50'(dym) * 50'(speed);
      OP_MUL_AX:  prod <= 50'(axm) * 50'(max_accel);
      OP_MUL_AY:  prod <= 50'(aym) * 50'(max_accel);
      OP_DIV_INIT: begin
        case (cmd.dsel)
          DSEL_SLOW: dvs <= {3'b0, radius_slow};
          DSEL_DIST: dvs <= {1'b0, dlen};
          DSEL_AMAG: dvs <= amag;
          default:   dvs <= amag;
        endcase
        drem <= {1'b0, prod[49:25]};
        dlow <= prod[24:0];
      end
      OP_DIV_STEP: begin
        drem <= d_ge ? d_diff[25:0] : d_t[25:0];
        dlow <= {dlow[23:0], d_ge};
      end
      OP_SPEED: begin
        // The stop test comes first; the proportional branch needs a nonzero radius.
        if (dlen < {2'b0, radius_stop}) speed <= '0;
        else if (dlen > {2'b0, radius_slow}) speed <= max_speed;
        else if (radius_slow == '0) speed <= '0;
        else speed <= dlow[SPEED_W-1:0];
      end
      OP_DESX: begin
        if (dlen == '0) desx <= '0;
        else desx <= dx[24] ? -$signed(q20) : $signed(q20);
      end
      OP_DESY: begin
        if (dlen == '0) desy <= '0;
        else desy <= dy[24] ? -$signed(q20) : $signed(q20);
      end
      OP_ACCEL: begin
        // Gain of 20 as 16 + 4.
        ax <= (ex26 <<< 4) + (ex26 <<< 2);
        ay <= (ey26 <<< 4) + (ey26 <<< 2);
      end
      OP_LIMX: begin
        if (amag > {2'b0, max_accel}) ax <= ax[25] ? -$signed(q26) : $signed(q26);
      end
      OP_LIMY: begin
        if (amag > {2'b0, max_accel}) ay <= ay[25] ? -$signed(q26) : $signed(q26);
      end
      OP_DV: begin
        dvx <= ax[25] ? -$signed({1'b0, pax[40:16]}) : $signed({1'b0, pax[40:16]});
        dvy <= ay[25] ? -$signed({1'b0, pay[40:16]}) : $signed({1'b0, pay[40:16]});
      end
      OP_DP: begin
        dpx <= velx[19] ? -$signed(pvx[35:16]) : $signed(pvx[35:16]);
        dpy <= vely[19] ? -$signed(pvy[35:16]) : $signed(pvy[35:16]);
      end
      OP_OUT: begin
        pos_x <= posx;
        pos_y <= posy;
        vel_x <= velx;
        vel_y <= vely;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/astr_ctrl.sv
// Controller of the arrive steering step: sequences the datapath operations
// and owns both handshakes. Depends on astr_pkg and the assertion macros.
`include "arrive_steering_step_top_defines.svh"
module astr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output astr_pkg::cmd_t cmd
);
  import astr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_SQ_D, S_SQRT_INIT, S_SQRT_STEP, S_DIST, S_MUL_SPD,
    S_DIV_INIT, S_DIV_STEP, S_SPEED, S_MUL_DX, S_DESX, S_MUL_DY, S_DESY,
    S_ACCEL, S_SQ_A, S_AMAG, S_MUL_AX, S_LIMX, S_MUL_AY, S_LIMY,
    S_DV, S_VEL, S_DP, S_POS, S_OUT
  } state_t;

  state_t           state, sqrt_ret, div_ret;
  dsel_t            dsel;
  logic [CNT_W-1:0] cnt;
  logic             slot_free;

  assign in_ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Command decode.
  always_comb begin
    cmd.dsel = dsel;
    case (state)
      S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_DIFF:      cmd.op = OP_DIFF;
      S_SQ_D:      cmd.op = OP_SQ_D;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT_STEP: cmd.op = OP_SQRT_STEP;
      S_DIST:      cmd.op = OP_DIST;
      S_MUL_SPD:   cmd.op = OP_MUL_SPD;
      S_DIV_INIT:  cmd.op = OP_DIV_INIT;
      S_DIV_STEP:  cmd.op = OP_DIV_STEP;
      S_SPEED:     cmd.op = OP_SPEED;
      S_MUL_DX:    cmd.op = OP_MUL_DX;
      S_DESX:      cmd.op = OP_DESX;
      S_MUL_DY:    cmd.op = OP_MUL_DY;
      S_DESY:      cmd.op = OP_DESY;
      S_ACCEL:     cmd.op = OP_ACCEL;
      S_SQ_A:      cmd.op = OP_SQ_A;
      S_AMAG:      cmd.op = OP_AMAG;
      S_MUL_AX:    cmd.op = OP_MUL_AX;
      S_LIMX:      cmd.op = OP_LIMX;
      S_MUL_AY:    cmd.op = OP_MUL_AY;
      S_LIMY:      cmd.op = OP_LIMY;
      S_DV:        cmd.op = OP_DV;
      S_VEL:       cmd.op = OP_VEL;
      S_DP:        cmd.op = OP_DP;
      S_POS:       cmd.op = OP_POS;
      S_OUT:       cmd.op = slot_free ? OP_OUT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sqrt_ret <= S_DIST;
      div_ret <= S_SPEED;
      dsel <= DSEL_SLOW;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new result is shown as the old one leaves or when the slot is empty.
      if (state == S_OUT && slot_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_DIFF;
        S_DIFF: state <= S_SQ_D;
        S_SQ_D: begin
          state <= S_SQRT_INIT;
          sqrt_ret <= S_DIST;
        end
        S_SQRT_INIT: begin
          state <= S_SQRT_STEP;
          cnt <= CNT_W'(SQRT_STEPS - 1);
        end
        S_SQRT_STEP: begin
          if (cnt == '0) state <= sqrt_ret;
          else cnt <= cnt - 1'b1;
        end
        S_DIST: state <= S_MUL_SPD;
        S_MUL_SPD: begin
          state <= S_DIV_INIT;
          dsel <= DSEL_SLOW;
          div_ret <= S_SPEED;
        end
        S_DIV_INIT: begin
          state <= S_DIV_STEP;
          cnt <= CNT_W'(DIV_STEPS - 1);
        end
        S_DIV_STEP: begin
          if (cnt == '0) state <= div_ret;
          else cnt <= cnt - 1'b1;
        end
        S_SPEED: state <= S_MUL_DX;
        S_MUL_DX: begin
          state <= S_DIV_INIT;
          dsel <= DSEL_DIST;
          div_ret <= S_DESX;
        end
        S_DESX: state <= S_MUL_DY;
        S_MUL_DY: begin
          state <= S_DIV_INIT;
          dsel <= DSEL_DIST;
          div_ret <= S_DESY;
        end
        S_DESY: state <= S_ACCEL;
        S_ACCEL: state <= S_SQ_A;
        S_SQ_A: begin
          state <= S_SQRT_INIT;
          sqrt_ret <= S_AMAG;
        end
        S_AMAG: state <= S_MUL_AX;
        S_MUL_AX: begin
          state <= S_DIV_INIT;
          dsel <= DSEL_AMAG;
          div_ret <= S_LIMX;
        end
        S_LIMX: state <= S_MUL_AY;
        S_MUL_AY: begin
          state <= S_DIV_INIT;
          dsel <= DSEL_AMAG;
          div_ret <= S_LIMY;
        end
        S_LIMY: state <= S_DV;
        S_DV: state <= S_VEL;
        S_VEL: state <= S_DP;
        S_DP: state <= S_POS;
        S_POS: state <= S_OUT;
        S_OUT: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASTR_ASSERT(a_one_item, clk, rst, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")
  `ASTR_ASSERT(a_div_cnt, clk, rst, (state == S_DIV_STEP) |-> (cnt < CNT_W'(DIV_STEPS)), "divide count out of range")
  `ASTR_ASSERT(a_valid_src, clk, rst, $rose(out_valid) |-> ($past(state) == S_OUT), "result shown outside output step")
  `ASTR_ASSERT(a_out_hold, clk, rst, (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT), "result overwritten before transfer")

endmodule

FILE: rtl/core/arrive_steering_step_top.sv
// Arrive steering step, one 2-D tick per input item. Each transfer on steer_in
// returns one result on steer_out; the next item is taken in the cycle after
// the result is registered. The block uses one shared restoring square root
// (used twice per item) and one shared restoring divider (used five times
// per item). A result that waits on steer_out does not block the next item
// until that item is finished.
// Configuration writes through cfg_write, cfg_index and cfg_data belong in idle.
module arrive_steering_step_top (
  input  logic                           clk,
  input  logic                           rst,
  astr_in_if.sink                        steer_in,
  astr_out_if.source                     steer_out,
  input  logic                           cfg_write,
  input  logic [astr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [astr_pkg::CFG_W-1:0]     cfg_data
);
  import astr_pkg::*;

  cmd_t cmd;
  logic in_ready, out_valid;

  // Handshakes and operation sequencing.
  astr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (steer_in.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (steer_out.ready),
    .cmd       (cmd)
  );

  assign steer_in.ready = in_ready;
  assign steer_out.valid = out_valid;

  // Arithmetic, state and configuration.
  astr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .target_x  (steer_in.target_x),
    .target_y  (steer_in.target_y),
    .time_step (steer_in.time_step),
    .pos_x     (steer_out.pos_x),
    .pos_y     (steer_out.pos_y),
    .vel_x     (steer_out.vel_x),
    .vel_y     (steer_out.vel_y)
  );

endmodule

FILE: test/arrive_steering_step_checker.sv
// Checker for the arrive steering step block: predicts each result and compares it.
// Depends on astr_pkg and the astr_in_if and astr_out_if interfaces.
module arrive_steering_step_checker
  import astr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  astr_in_if                   in_ch,
  astr_out_if                  out_ch,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
  } steer_state_t;

  steer_state_t expected_states[$];

  // Settings and motion state as tracked by the predictor.
  longint unsigned lim_speed, lim_accel, stop_rad, slow_rad;
  longint cur_px, cur_py, cur_vx, cur_vy;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // v * mul / div with truncation toward zero; zero for a zero divisor.
  function automatic longint ratio_tz(longint v, longint unsigned mul, longint unsigned div);
    longint unsigned q;
    if (div == 0) return 0;
    q = (v < 0 ? longint'(-v) : v) * mul / div;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_speed(longint v);
    longint l;
    l = longint'(lim_speed);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic longint sat_position(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // One steering tick: advances the tracked state and returns the new state.
  function automatic steer_state_t steer_tick(longint tx, longint ty, longint unsigned dt);
    longint dx, dy, ax, ay;
    longint unsigned span, speed, amag, mx, my;
    steer_state_t r;
    dx = tx - cur_px;
    dy = ty - cur_py;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    span = int_sqrt(mx * mx + my * my);
    if (span < stop_rad) speed = 0;
    else if (span > slow_rad) speed = lim_speed;
    else if (slow_rad == 0) speed = 0;
    else speed = lim_speed * span / slow_rad;
    ax = 20 * (ratio_tz(dx, speed, span) - cur_vx);
    ay = 20 * (ratio_tz(dy, speed, span) - cur_vy);
    mx = ax < 0 ? -ax : ax;
    my = ay < 0 ? -ay : ay;
    amag = int_sqrt(mx * mx + my * my);
    if (amag > lim_accel) begin
      ax = ratio_tz(ax, lim_accel, amag);
      ay = ratio_tz(ay, lim_accel, amag);
    end
    cur_vx = clamp_speed(cur_vx + ratio_tz(ax, dt, 65536));
    cur_vy = clamp_speed(cur_vy + ratio_tz(ay, dt, 65536));
    cur_px = sat_position(cur_px + ratio_tz(cur_vx, dt, 65536));
    cur_py = sat_position(cur_py + ratio_tz(cur_vy, dt, 65536));
    r.pos_x = cur_px[POS_W-1:0];
    r.pos_y = cur_py[POS_W-1:0];
    r.vel_x = cur_vx[VEL_W-1:0];
    r.vel_y = cur_vy[VEL_W-1:0];
    return r;
  endfunction

  // Track register writes, predict on input transfers, compare output transfers.
  always @(posedge clk) begin
    steer_state_t exp_s, got_s;
    if (rst) begin
      lim_speed <= MAX_SPEED_RST;
      lim_accel <= MAX_ACCEL_RST;
      stop_rad <= RADIUS_STOP_RST;
      slow_rad <= RADIUS_SLOW_RST;
      cur_px = 0;
      cur_py = 0;
      cur_vx = 0;
      cur_vy = 0;
      expected_states.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAX_SPEED:   lim_speed <= cfg_data[SPEED_W-1:0];
          CFG_MAX_ACCEL:   lim_accel <= cfg_data[ACCEL_W-1:0];
          CFG_RADIUS_STOP: stop_rad <= cfg_data[RAD_W-1:0];
          CFG_RADIUS_SLOW: slow_rad <= cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_states.insert(expected_states.size(),
                               steer_tick(in_ch.target_x, in_ch.target_y,
                                          in_ch.time_step));
      if (out_ch.valid && out_ch.ready) begin
        got_s = '{out_ch.pos_x, out_ch.pos_y, out_ch.vel_x, out_ch.vel_y};
        results_seen <= results_seen + 1;
        if (expected_states.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] result with nothing expected: pos %0d,%0d vel %0d,%0d",
                     $realtime, got_s.pos_x, got_s.pos_y, got_s.vel_x, got_s.vel_y);
          fail_count <= fail_count + 1;
        end else begin
          exp_s = expected_states.pop_front();
          if (got_s !== exp_s) begin
            if (fail_count < 10)
              $display("[%0t] result %0d: expected pos %0d,%0d vel %0d,%0d got pos %0d,%0d vel %0d,%0d",
                       $realtime, results_seen, exp_s.pos_x, exp_s.pos_y, exp_s.vel_x,
                       exp_s.vel_y, got_s.pos_x, got_s.pos_y, got_s.vel_x, got_s.vel_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    // Number of predicted results still waiting for their transfer.
    pending = expected_states.size();
  end
endmodule

FILE: test/arrive_steering_step_top_tb.sv
// Testbench top for the arrive steering step block: stimulus, register phases, verdict.
// Depends on astr_pkg, the channel interfaces and arrive_steering_step_checker.
module arrive_steering_step_top_tb;
  import astr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_SPEED;
  logic [CFG_W-1:0] cfg_data = '0;
  logic no_idle = 1'b0;
  int fail_count, pending, results_seen;
  int cycles = 0;
  int items_sent = 0;
  logic signed [POS_W-1:0] hold_x = '0, hold_y = '0;

  astr_in_if steer_in_ch();
  astr_out_if steer_out_ch();

  arrive_steering_step_top u_dut (
    .clk(clk), .rst(rst), .steer_in(steer_in_ch), .steer_out(steer_out_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  arrive_steering_step_checker u_checker (
    .clk(clk), .rst(rst), .in_ch(steer_in_ch), .out_ch(steer_out_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  always #4 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("arrive_steering_step_top: mismatch");
      $finish;
    end
  end

  // Output back-pressure, off during the no-idle stretch.
  initial steer_out_ch.ready = 1'b0;
  always @(negedge clk)
    steer_out_ch.ready = no_idle || ($urandom_range(0, 99) >= 13);

  // One input transfer with random idle cycles ahead of it.
  task automatic send_tick(logic signed [POS_W-1:0] tx, logic signed [POS_W-1:0] ty,
                           logic [DT_W-1:0] dt);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 13) begin
      steer_in_ch.valid = 1'b0;
      @(negedge clk);
    end
    steer_in_ch.valid = 1'b1;
    steer_in_ch.target_x = tx;
    steer_in_ch.target_y = ty;
    steer_in_ch.time_step = dt;
    do @(posedge clk); while (!steer_in_ch.ready);
    items_sent++;
  endtask

  // Register write once the block has drained and gone quiet.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    steer_in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_limits(logic [CFG_W-1:0] spd, logic [CFG_W-1:0] acc,
                            logic [CFG_W-1:0] stop_r, logic [CFG_W-1:0] slow_r);
    write_reg(CFG_MAX_SPEED, spd);
    write_reg(CFG_MAX_ACCEL, acc);
    write_reg(CFG_RADIUS_STOP, stop_r);
    write_reg(CFG_RADIUS_SLOW, slow_r);
  endtask

  function automatic logic [DT_W-1:0] pick_dt();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return DT_W'($urandom);
      default: return DT_W'($urandom_range(1, 8000));
    endcase
  endfunction

  // Half of the targets steady so the vehicle arrives; the rest scattered.
  task automatic random_ticks(int count);
    logic signed [POS_W-1:0] tx, ty;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          if ($urandom_range(0, 7) == 0) begin
            hold_x = POS_W'($urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 65535)) - 32768);
            hold_y = POS_W'($urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 65535)) - 32768);
          end
          tx = hold_x;
          ty = hold_y;
        end
        5, 6: begin
          tx = POS_W'($signed($urandom_range(0, 40000)) - 20000);
          ty = POS_W'($signed($urandom_range(0, 40000)) - 20000);
        end
        default: begin
          tx = POS_W'($urandom);
          ty = POS_W'($urandom);
        end
      endcase
      send_tick(tx, ty, pick_dt());
    end
  endtask

  initial begin
    steer_in_ch.valid = 1'b0;
    steer_in_ch.target_x = '0;
    steer_in_ch.target_y = '0;
    steer_in_ch.time_step = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed ticks at reset settings: zero distance, zero and full time step,
    // field extremes, targets inside the stop and slow radii.
    send_tick('0, '0, 16'd4096);
    send_tick(24'sd4000, -24'sd3000, 16'd0);
    send_tick(24'sd4000, -24'sd3000, '1);
    send_tick(24'sd1000, 24'sd500, 16'd2000);
    send_tick(24'sd8388607, 24'sd8388607, '1);
    send_tick(-24'sd8388608, -24'sd8388608, '1);
    send_tick(-24'sd8388608, 24'sd8388607, 16'd1);
    send_tick(24'sd12000, 24'sd10000, 16'd30000);
    random_ticks(80);

    // Fastest settings: the position is driven into saturation.
    set_limits(24'h7FFFF, 24'hFFFFFF, 24'd0, 24'h7FFFFF);
    repeat (16) send_tick(24'sd8388607, -24'sd8388608, '1);
    random_ticks(80);

    // Everything zero, stop radius far above the slow radius.
    set_limits(24'hF80000, 24'd0, 24'hFFFFFF, 24'd1);
    random_ticks(70);

    // Slow radius of one, no idling on either side.
    no_idle = 1'b1;
    set_limits(24'd100000, 24'hFFFFFF, 24'd0, 24'd1);
    random_ticks(90);
    no_idle = 1'b0;

    // Tight acceleration limit, stop radius above slow radius.
    set_limits(24'd25600, 24'd3000, 24'd50000, 24'd8000);
    random_ticks(90);

    // Random settings, with upper data bits that the registers drop.
    set_limits(CFG_W'($urandom), CFG_W'($urandom_range(1000, 2000000)),
               CFG_W'($urandom_range(0, 30000)), CFG_W'($urandom_range(1, 200000)));
    random_ticks(90);

    @(negedge clk);
    steer_in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d steering ticks over six register settings, checked %0d results.",
             items_sent, results_seen);
    $display("Failures: %0d, cycles used: %0d.", fail_count, cycles);
    if (fail_count == 0)
      $display("arrive_steering_step_top: match");
    else
      $display("arrive_steering_step_top: mismatch");
    $finish;
  end
endmodule
